@@ hw/rtl/skvt_pkg.sv @@
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Widths of the word fields on the ports.
   localparam int CMD_W       = 2;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_USER_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET      = 2'd0,
      CMD_WRITE    = 2'd1,
      CMD_ERASE    = 2'd2,
      CMD_CONTAINS = 2'd3
   } cmd_type;

   // Update broadcast to every cell for the accepted word.
   typedef struct packed {
      logic insert;  // open a slot at the insertion point
      logic erase;   // close the slot of the matching key
      logic write;   // store the request value at the key's slot
   } ctrl_type;

endpackage

@@ hw/rtl/skvt_cell.sv @@
// One slot of the sorted chain: holds a key/value pair and shifts with its neighbors.
module skvt_cell #(
   parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  skvt_pkg::ctrl_type    ctrl,
   input  logic                  occupied,
   input  logic [KEY_BITS-1:0]   lookup_key,
   input  logic [VALUE_BITS-1:0] write_value,
   input  logic                  left_lt,
   input  logic [KEY_BITS-1:0]   left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [KEY_BITS-1:0]   right_key,
   input  logic [VALUE_BITS-1:0] right_value,
   output logic                  lt,
   output logic                  hit,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic [VALUE_BITS-1:0] hit_value
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  at_pos;

   assign lt        = occupied && (key_ff < lookup_key);
   assign hit       = occupied && (key_ff == lookup_key);
   assign at_pos    = !lt && left_lt;
   assign key       = key_ff;
   assign value     = value_ff;
   assign hit_value = hit ? value_ff : '0;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.insert && !lt) begin
         if (at_pos) begin
            key_in   = lookup_key;
            value_in = ctrl.write ? write_value : '0;
         end else begin
            key_in   = left_key;
            value_in = left_value;
         end
      end else if (ctrl.erase && !lt) begin
         key_in   = right_key;
         value_in = right_value;
      end else if (ctrl.write && hit) begin
         value_in = write_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

@@ hw/rtl/sorted_key_value_table_core.sv @@
// Top level of the sorted key/value table: a chain of cells plus the response register.
// Response: a word appears on the rsp_ side in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_tready holds; every cell compares its key
// in parallel and shifts with its neighbors in that cycle, so each word takes a single step.
// Reset: synchronous, active high; it empties the table (entry count zero) and drops any
// pending response. Stored keys and values are not cleared and are only read once written.
module sorted_key_value_table_core #(
   parameter int CAPACITY   = skvt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: key [31:0], value [63:32]
   input  logic [skvt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: command [1:0]
   input  logic [skvt_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: read_value [31:0], entry_count [38:32], zero pad [39]
   output logic [skvt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: found [0], full_refused [1]
   output logic [skvt_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   // Request fields, cut or widened to the stored widths.
   skvt_pkg::cmd_type      cmd;
   logic [KEY_BITS-1:0]    lookup_key;
   logic [VALUE_BITS-1:0]  write_value;
   logic                   accept;

   // Chain wiring between neighboring cells.
   logic [KEY_BITS-1:0]    cell_key   [CAPACITY];
   logic [VALUE_BITS-1:0]  cell_value [CAPACITY];
   logic [VALUE_BITS-1:0]  cell_hitv  [CAPACITY];
   logic                   cell_lt    [CAPACITY];
   logic                   cell_hit   [CAPACITY];

   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;

   logic                   present;
   logic [VALUE_BITS-1:0]  present_value;
   logic                   is_full;
   logic                   wants_insert;
   logic                   refused;
   skvt_pkg::ctrl_type     ctrl;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [skvt_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [skvt_pkg::VALUE_W-1:0] rsp_value_in;
   logic [skvt_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [skvt_pkg::COUNT_W-1:0] rsp_count_in;
   logic                   rsp_found_ff;
   logic                   rsp_refused_ff;

   assign cmd         = skvt_pkg::cmd_type'(req_tuser);
   assign lookup_key  = KEY_BITS'(req_tdata[skvt_pkg::KEY_W-1:0]);
   assign write_value = VALUE_BITS'(req_tdata[skvt_pkg::KEY_W +: skvt_pkg::VALUE_W]);

   // The response register frees up in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // The hit flags are one-hot at most because keys stay strictly ascending,
   // so the matching value is a plain OR over all cells.
   always_comb begin
      present       = 1'b0;
      present_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         present       = present | cell_hit[i];
         present_value = present_value | cell_hitv[i];
      end
   end

   assign is_full      = (count_ff == CNT_BITS'(CAPACITY));
   assign wants_insert = ((cmd == skvt_pkg::CMD_GET) || (cmd == skvt_pkg::CMD_WRITE)) &&
                         !present;
   assign refused      = wants_insert && is_full;

   always_comb begin
      ctrl.insert = accept && wants_insert && !is_full;
      ctrl.erase  = accept && (cmd == skvt_pkg::CMD_ERASE) && present;
      ctrl.write  = accept && (cmd == skvt_pkg::CMD_WRITE) && !refused;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.erase) begin
         count_in = count_ff - 1'b1;
      end
   end

   // The returned value follows the command: a write echoes what it stored,
   // a lookup returns the held value (zero for a fresh or refused insert),
   // and an erase always returns zero since the key is gone afterwards.
   always_comb begin
      case (cmd)
         skvt_pkg::CMD_GET: begin
            rsp_value_in = skvt_pkg::VALUE_W'(present_value);
         end
         skvt_pkg::CMD_WRITE: begin
            rsp_value_in = refused ? '0 : skvt_pkg::VALUE_W'(write_value);
         end
         skvt_pkg::CMD_CONTAINS: begin
            rsp_value_in = skvt_pkg::VALUE_W'(present_value);
         end
         default: begin
            rsp_value_in = '0;
         end
      endcase
   end

   assign rsp_count_in = skvt_pkg::COUNT_W'(count_in);
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                  left_lt;
      logic [KEY_BITS-1:0]   left_key;
      logic [VALUE_BITS-1:0] left_value;
      logic [KEY_BITS-1:0]   right_key;
      logic [VALUE_BITS-1:0] right_value;
      logic                  occupied;

      assign occupied = (count_ff > CNT_BITS'(g));

      if (g == 0) begin : g_head
         // The head slot is the insertion point whenever its key is not below.
         assign left_lt    = 1'b1;
         assign left_key   = lookup_key;
         assign left_value = write_value;
      end else begin : g_body
         assign left_lt    = cell_lt[g-1];
         assign left_key   = cell_key[g-1];
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         // On erase the last slot leaves the occupied range, so its contents do not matter.
         assign right_key   = cell_key[g];
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_key   = cell_key[g+1];
         assign right_value = cell_value[g+1];
      end

      skvt_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .lookup_key  (lookup_key),
         .write_value (write_value),
         .left_lt     (left_lt),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .lt          (cell_lt[g]),
         .hit         (cell_hit[g]),
         .key         (cell_key[g]),
         .value       (cell_value[g]),
         .hit_value   (cell_hitv[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_found_ff   <= present;
         rsp_refused_ff <= refused;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_refused_ff, rsp_found_ff};

endmodule

@@ hw/rtl/skvt_checker.sv @@
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_checker #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [skvt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [skvt_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam logic [skvt_pkg::COUNT_W-1:0] FULL_COUNT = skvt_pkg::COUNT_W'(CAPACITY);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // Every accepted request yields a response word in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after an accepted request");

   // With the response slot blocked no new request may enter.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while the response slot was blocked");

   // A refused insert only happens on a full table, for a key that was absent,
   // and returns zero.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         !rsp_tuser[0] && (rsp_tdata[38:32] == FULL_COUNT) && (rsp_tdata[31:0] == '0))
      else $error("inconsistent refused insert");

endmodule

bind sorted_key_value_table_core skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
